>>> sv/hc_pkg.sv
// types, constants and arithmetic helpers shared by the hill cipher block
`default_nettype none
package hc_pkg;

    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned ROW_W = 15;
    localparam int unsigned LTR_W = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_ROW_ZERO = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_ROW_ONE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_ROW_TWO = 2'd2;

    localparam logic [ROW_W-1:0] KEY_ROW_ZERO_RST = 15'd1798;
    localparam logic [ROW_W-1:0] KEY_ROW_ONE_RST = 15'd10765;
    localparam logic [ROW_W-1:0] KEY_ROW_TWO_RST = 15'd15924;

    typedef logic [2:0][LTR_W-1:0] t_tri;
    typedef logic [2:0][2:0][LTR_W-1:0] t_mat;

    // key as seen by the datapath: reduced key, adjugate mod 26, inverse determinant
    typedef struct packed {
        t_mat key;
        t_mat adj;
        logic [LTR_W-1:0] inv;
    } t_key_info;

    function automatic logic [4:0] red5(input logic [4:0] x);
        return (x >= 5'd26) ? 5'(x - 5'd26) : x;
    endfunction

    function automatic logic [9:0] mul5(input logic [4:0] a, input logic [4:0] b);
        return {5'd0, a} * {5'd0, b};
    endfunction

    // exact x mod 26, using floor(x/26) by reciprocal, for any 11-bit x (below 2048)
    function automatic logic [4:0] mod26(input logic [10:0] x);
        logic [23:0] prod;
        logic [10:0] rem;
        prod = {13'd0, x} * 24'd2521;
        rem = x - 11'({3'd0, prod[23:16]} * 11'd26);
        return rem[4:0];
    endfunction

    function automatic logic [4:0] inv26(input logic [4:0] d);
        logic [4:0] r;
        case (d)
            5'd1: r = 5'd1;
            5'd3: r = 5'd9;
            5'd5: r = 5'd21;
            5'd7: r = 5'd15;
            5'd9: r = 5'd3;
            5'd11: r = 5'd19;
            5'd15: r = 5'd7;
            5'd17: r = 5'd23;
            5'd19: r = 5'd11;
            5'd21: r = 5'd5;
            5'd23: r = 5'd17;
            5'd25: r = 5'd25;
            default: r = 5'd0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

>>> sv/hc_if.sv
// valid/ready channel interfaces for the letter stream and the key writes
`default_nettype none
interface hc_in_if;
    logic valid;
    logic ready;
    logic mode;
    logic [4:0] letter_a;
    logic [4:0] letter_b;
    logic [4:0] letter_c;
    modport source(output valid, mode, letter_a, letter_b, letter_c, input ready);
    modport sink(input valid, mode, letter_a, letter_b, letter_c, output ready);
endinterface

interface hc_out_if;
    logic valid;
    logic ready;
    logic [4:0] out_a;
    logic [4:0] out_b;
    logic [4:0] out_c;
    logic key_not_invertible;
    modport source(output valid, out_a, out_b, out_c, key_not_invertible, input ready);
    modport sink(input valid, out_a, out_b, out_c, key_not_invertible, output ready);
endinterface

interface hc_cfg_if;
    logic valid;
    logic ready;
    logic [1:0] index;
    logic [14:0] data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> sv/hc_keygen.sv
// free-running key chain: reduced key, adjugate, determinant and its inverse mod 26
`default_nettype none
module hc_keygen (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire hc_pkg::t_mat     i_key_raw,
    output hc_pkg::t_key_info     o_info
);
    import hc_pkg::*;

    t_mat w_k;
    logic [2:0][2:0][9:0] n_pos, n_neg;

    t_mat r_key1;
    logic [2:0][2:0][9:0] r_pos1, r_neg1;
    t_mat r_key2;
    t_mat r_adj2;
    logic [10:0] r_det3;
    logic [4:0] r_inv4;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                w_k[i][j] = red5(i_key_raw[i][j]);
            end
        end
        // cofactor pairs, adjugate entry is pos - neg
        n_pos[0][0] = mul5(w_k[1][1], w_k[2][2]); n_neg[0][0] = mul5(w_k[1][2], w_k[2][1]);
        n_pos[0][1] = mul5(w_k[0][2], w_k[2][1]); n_neg[0][1] = mul5(w_k[0][1], w_k[2][2]);
        n_pos[0][2] = mul5(w_k[0][1], w_k[1][2]); n_neg[0][2] = mul5(w_k[0][2], w_k[1][1]);
        n_pos[1][0] = mul5(w_k[1][2], w_k[2][0]); n_neg[1][0] = mul5(w_k[1][0], w_k[2][2]);
        n_pos[1][1] = mul5(w_k[0][0], w_k[2][2]); n_neg[1][1] = mul5(w_k[0][2], w_k[2][0]);
        n_pos[1][2] = mul5(w_k[0][2], w_k[1][0]); n_neg[1][2] = mul5(w_k[0][0], w_k[1][2]);
        n_pos[2][0] = mul5(w_k[1][0], w_k[2][1]); n_neg[2][0] = mul5(w_k[1][1], w_k[2][0]);
        n_pos[2][1] = mul5(w_k[0][1], w_k[2][0]); n_neg[2][1] = mul5(w_k[0][0], w_k[2][1]);
        n_pos[2][2] = mul5(w_k[0][0], w_k[1][1]); n_neg[2][2] = mul5(w_k[0][1], w_k[1][0]);
    end

    always_ff @(posedge i_clk) begin
        r_key1 <= w_k;
        r_pos1 <= n_pos;
        r_neg1 <= n_neg;
        r_key2 <= r_key1;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                // offset by 650 keeps the difference positive
                r_adj2[i][j] <= mod26(11'd650 + {1'b0, r_pos1[i][j]} - {1'b0, r_neg1[i][j]});
            end
        end
        r_det3 <= {1'b0, mul5(r_key2[0][0], r_adj2[0][0])}
                + {1'b0, mul5(r_key2[0][1], r_adj2[1][0])}
                + {1'b0, mul5(r_key2[0][2], r_adj2[2][0])};
        r_inv4 <= inv26(mod26(r_det3));
    end

    // datapath reads each part once the user lets the chain catch up; not enforced
    assign o_info.key = r_key1;
    assign o_info.adj = r_adj2;
    assign o_info.inv = r_inv4;

    ap_inv_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_inv4 != 5'd0) |-> (r_inv4[0] && (r_inv4 != 5'd13)))
        else $error("inverse determinant is not a unit mod 26");

    ap_key_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_key1[0][0] < 5'd26) && (r_key1[1][1] < 5'd26) && (r_key1[2][2] < 5'd26)
        |=> (r_key2[0][0] < 5'd26) && (r_key2[1][1] < 5'd26) && (r_key2[2][2] < 5'd26))
        else $error("reduced key entry out of range");

    ap_adj_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_adj2[0][0] < 5'd26) && (r_adj2[1][1] < 5'd26) && (r_adj2[2][1] < 5'd26))
        else $error("adjugate entry out of range");

endmodule
`default_nettype wire

>>> sv/hc_datapath.sv
// six-stage letter pipeline: capture, reduce, matrix product, mod, scale, mod and select
`default_nettype none
module hc_datapath (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire hc_pkg::t_key_info i_info,
    hc_in_if.sink                  i_in,
    hc_out_if.source               o_out
);
    import hc_pkg::*;

    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6;
    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4, w_rdy5, w_rdy6;

    logic r_mode1, r_mode2, r_mode3, r_mode4, r_mode5;
    t_tri r_raw1, r_raw2, r_raw3, r_raw4, r_raw5;
    t_tri r_v_ltr2;
    logic [2:0][10:0] r_sum3;
    t_tri r_red4;
    logic [2:0][9:0] r_scl5;
    logic r_bad5;
    t_tri r_out6;
    logic r_bad6;

    t_mat w_mat;
    logic [2:0][10:0] n_sum3;
    logic [2:0][9:0] n_scl5;
    logic n_bad5;
    t_tri n_out6;

    assign w_rdy6 = !r_v6 || o_out.ready;
    assign w_rdy5 = !r_v5 || w_rdy6;
    assign w_rdy4 = !r_v4 || w_rdy5;
    assign w_rdy3 = !r_v3 || w_rdy4;
    assign w_rdy2 = !r_v2 || w_rdy3;
    assign w_rdy1 = !r_v1 || w_rdy2;
    assign i_in.ready = w_rdy1;

    always_comb begin
        w_mat = r_mode2 ? i_info.adj : i_info.key;
        for (int i = 0; i < 3; i++) begin
            n_sum3[i] = {1'b0, mul5(w_mat[i][0], r_v_ltr2[0])}
                      + {1'b0, mul5(w_mat[i][1], r_v_ltr2[1])}
                      + {1'b0, mul5(w_mat[i][2], r_v_ltr2[2])};
            n_scl5[i] = r_mode4 ? mul5(i_info.inv, r_red4[i]) : {5'd0, r_red4[i]};
            n_out6[i] = r_bad5 ? r_raw5[i] : mod26({1'b0, r_scl5[i]});
        end
        n_bad5 = r_mode4 && (i_info.inv == 5'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_in.valid;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
            if (w_rdy4) r_v4 <= r_v3;
            if (w_rdy5) r_v5 <= r_v4;
            if (w_rdy6) r_v6 <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_mode1 <= i_in.mode;
            r_raw1 <= {i_in.letter_c, i_in.letter_b, i_in.letter_a};
        end
        if (w_rdy2) begin
            r_mode2 <= r_mode1;
            r_raw2 <= r_raw1;
            for (int i = 0; i < 3; i++) begin
                r_v_ltr2[i] <= red5(r_raw1[i]);
            end
        end
        if (w_rdy3) begin
            r_mode3 <= r_mode2;
            r_raw3 <= r_raw2;
            r_sum3 <= n_sum3;
        end
        if (w_rdy4) begin
            r_mode4 <= r_mode3;
            r_raw4 <= r_raw3;
            for (int i = 0; i < 3; i++) begin
                r_red4[i] <= mod26(r_sum3[i]);
            end
        end
        if (w_rdy5) begin
            r_mode5 <= r_mode4;
            r_raw5 <= r_raw4;
            r_scl5 <= n_scl5;
            r_bad5 <= n_bad5;
        end
        if (w_rdy6) begin
            r_out6 <= n_out6;
            r_bad6 <= r_bad5;
        end
    end

    assign o_out.valid = r_v6;
    assign o_out.out_a = r_out6[0];
    assign o_out.out_b = r_out6[1];
    assign o_out.out_c = r_out6[2];
    assign o_out.key_not_invertible = r_bad6;

    ap_result_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v6 && !r_bad6) |-> (r_out6[0] < 5'd26) && (r_out6[1] < 5'd26)
                              && (r_out6[2] < 5'd26))
        else $error("result letter out of range");

    ap_bad_only_decrypt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v5 && r_bad5) |-> r_mode5)
        else $error("error flag raised on an encrypt request");

    ap_entry_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && w_rdy1) |=> r_v1)
        else $error("accepted request missing from first stage");

    ap_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v5 && !w_rdy5) |=> (r_v5 && $stable(r_scl5) && $stable(r_bad5)))
        else $error("stalled stage lost its request");

endmodule
`default_nettype wire

>>> sv/hill_cipher_3x3_mod26.sv
// Hill cipher 3x3 mod 26 top level: key registers, key chain and letter pipeline
//
//  channel  dir  handshake            payload
//  i_in     in   i_in.valid/ready     mode, letter_a, letter_b, letter_c
//  o_out    out  o_out.valid/ready    out_a, out_b, out_c, key_not_invertible
//  i_cfg    in   i_cfg.valid/ready    index (key row 0..2), data (15 bits)
//
//  one request per cycle sustained while o_out is ready; each request passes six register stages
//  after a key write the key chain settles through r_key1, r_adj2, r_det3 and r_inv4; requests are not held for it
//  i_rst_n is synchronous: empties the pipeline and restores the default key
//  a stall on o_out backs up stage by stage; empty stages still take new requests
//  i_cfg is always ready; writes to index 3 are dropped
`default_nettype none
module hill_cipher_3x3_mod26 (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    hc_in_if.sink     i_in,
    hc_out_if.source  o_out,
    hc_cfg_if.sink    i_cfg
);
    import hc_pkg::*;

    logic [ROW_W-1:0] r_key_row0, r_key_row1, r_key_row2;
    t_mat w_key_raw;
    t_key_info w_info;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_row0 <= KEY_ROW_ZERO_RST;
            r_key_row1 <= KEY_ROW_ONE_RST;
            r_key_row2 <= KEY_ROW_TWO_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_KEY_ROW_ZERO: r_key_row0 <= i_cfg.data;
                CFG_KEY_ROW_ONE: r_key_row1 <= i_cfg.data;
                CFG_KEY_ROW_TWO: r_key_row2 <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            w_key_raw[0][j] = r_key_row0[5*j +: 5];
            w_key_raw[1][j] = r_key_row1[5*j +: 5];
            w_key_raw[2][j] = r_key_row2[5*j +: 5];
        end
    end

    hc_keygen u_keygen (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_key_raw (w_key_raw),
        .o_info    (w_info)
    );

    hc_datapath u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_info  (w_info),
        .i_in    (i_in),
        .o_out   (o_out)
    );

endmodule
`default_nettype wire
